// ----- src/vlm_pkg.sv -----
// Shared constants and helpers for the volume Laplacian unit.
// No dependencies; imported by the RAM, the delay line and the top level.
package vlm_pkg;

  localparam int MAX_X_DEF       = 256;
  localparam int MAX_Y_DEF       = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int LAP_W    = 20;
  localparam int M_DATA_W = ((LAP_W + 7) / 8) * 8;

  localparam int SIZE_XY_W = 9;
  localparam int SIZE_Z_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // z term is applied only for depths above this
  localparam int Z_MIN_DEPTH = 3;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ----- src/vlm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on vlm_pkg for the address width helper.
module vlm_ram
  import vlm_pkg::*;
#(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [addr_w(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [addr_w(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/vlm_delay.sv -----
// Variable-length delay line built on one vlm_ram: advances by one entry per shift.
// Depends on vlm_pkg and vlm_ram.
module vlm_delay
  import vlm_pkg::*;
#(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int LEN_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             shift,
  input  logic [LEN_W-1:0] len,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  localparam int AW = addr_w(DEPTH);

  logic [AW-1:0]    ptr;
  logic [AW-1:0]    ptr_next;
  logic [AW-1:0]    raddr;
  logic [WIDTH-1:0] rdata;
  logic [WIDTH-1:0] hold;

  // ring of len entries: read the oldest entry, then overwrite it
  assign ptr_next = (32'(ptr) + 32'd1 >= 32'(len)) ? '0 : ptr + AW'(1);
  // prefetch the entry the next shift will need
  assign raddr    = shift ? ptr_next : ptr;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      ptr <= '0;
    end else if (shift) begin
      ptr <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      hold <= din;
    end
  end

  vlm_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (shift),
    .waddr(ptr),
    .wdata(din),
    .raddr(raddr),
    .rdata(rdata)
  );

  // a one-entry ring reads back what was just written
  assign dout = (len == LEN_W'(1)) ? hold : rdata;

endmodule

// ----- src/volume_laplacian_mirror_unit.sv -----
// Streaming 7-point Laplacian with mirrored borders. Voxels arrive in raster order (x fastest,
// then y, then z) as transactions with tuser = 0; the result for voxel k leaves with the
// transaction that carries voxel k + size_x*size_y, and after the last voxel, transactions with
// tuser = 1 release the remaining results, one each (with tlast on the volume's final voxel).
// One transaction is taken every cycle unless the output stalls; a result passes the input
// register, then the result register. The neighbourhood comes from four delay lines in RAM
// (two of one plane minus a row, two of a row minus one) plus two registers, each RAM read
// prefetched one shift ahead, so no RAM port limits the rate. RAM contents need no clearing
// after reset. s_tready follows m_tready combinationally when the input and result registers
// both hold results. The user must write the size registers only while the unit is idle; the
// unit does not enforce this. A write restarts the volume. Depends on vlm_pkg and vlm_delay.
module volume_laplacian_mirror_unit
  import vlm_pkg::*;
#(
  parameter int MAX_X       = MAX_X_DEF,
  parameter int MAX_Y       = MAX_Y_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // sample
  input  logic                                  s_tuser,  // cmd
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [M_DATA_W-1:0]                   m_tdata,  // lap_value
  output logic                                  m_tlast,  // last_voxel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_DATA_W-1:0]                 cfg_data
);

  localparam int XCW      = $clog2(MAX_X);
  localparam int YCW      = $clog2(MAX_Y);
  localparam int PR_DEPTH = MAX_X * (MAX_Y - 1);
  localparam int PR_LEN_W = $clog2(PR_DEPTH + 1);
  localparam int ROW_DEPTH = MAX_X - 1;
  localparam int ROW_LEN_W = $clog2(ROW_DEPTH + 1);
  localparam int ACC_W    = (SAMPLE_BITS + 4 > LAP_W) ? SAMPLE_BITS + 4 : LAP_W;

  typedef struct packed {
    logic shift;
    logic emit;
    logic last;
    logic x_lo;
    logic x_hi;
    logic y_lo;
    logic y_hi;
    logic z_lo;
    logic z_hi;
    logic z_en;
  } ctl_t;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  // configuration
  logic [SIZE_XY_W-1:0] size_x;
  logic [SIZE_XY_W-1:0] size_y;
  logic [SIZE_Z_W-1:0]  size_z;
  logic                 cfg_hit;
  logic [XCW-1:0]       sxm1;
  logic [YCW-1:0]       sym1;
  logic [SIZE_Z_W-1:0]  szm1;
  logic                 z_en;
  logic [PR_LEN_W-1:0]  len_pr;

  // stream position
  logic [XCW-1:0]        in_x;
  logic [YCW-1:0]        in_y;
  logic [SIZE_Z_W:0]     in_z;
  logic [XCW-1:0]        ox;
  logic [YCW-1:0]        oy;
  logic [SIZE_Z_W-1:0]   oz;

  logic   accept;
  logic   can_take;
  ctl_t   ctl_next;
  ctl_t   s1_ctl;
  logic   s1_valid;
  smp_t   s1_sample;
  logic   s1_go;
  logic   out_free;
  logic   chain_shift;

  smp_t tap_zp, tap_yp, tap_xp, tap_c, tap_xm, tap_ym, tap_zm;
  logic signed [ACC_W-1:0] c_e, xsum, ysum, zsum, acc;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y ||
                                   cfg_index == REG_SIZE_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_XY_W'(256);
      size_y <= SIZE_XY_W'(256);
      size_z <= SIZE_Z_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SIZE_X: size_x <= cfg_data[SIZE_XY_W-1:0];
        REG_SIZE_Y: size_y <= cfg_data[SIZE_XY_W-1:0];
        REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // sizes in use: x and y saturated to [2, MAX], depth zero taken as one
  always_comb begin
    if (32'(size_x) < 32'd2) begin
      sxm1 = XCW'(1);
    end else if (32'(size_x) > 32'(MAX_X)) begin
      sxm1 = XCW'(MAX_X - 1);
    end else begin
      sxm1 = XCW'(32'(size_x) - 32'd1);
    end
    if (32'(size_y) < 32'd2) begin
      sym1 = YCW'(1);
    end else if (32'(size_y) > 32'(MAX_Y)) begin
      sym1 = YCW'(MAX_Y - 1);
    end else begin
      sym1 = YCW'(32'(size_y) - 32'd1);
    end
  end

  assign szm1 = (size_z == '0) ? '0 : size_z - SIZE_Z_W'(1);
  assign z_en = 32'(size_z) > Z_MIN_DEPTH;

  // plane minus one row
  always_ff @(posedge clk) begin
    len_pr <= (PR_LEN_W'(sxm1) + PR_LEN_W'(1)) * PR_LEN_W'(sym1);
  end

  // decide what the incoming transaction does
  assign out_free = !m_tvalid || m_tready;
  assign s1_go    = !s1_ctl.emit || out_free;
  assign s_tready = !s1_valid || s1_go;
  assign accept   = s_tvalid && s_tready;
  assign can_take = in_z <= (SIZE_Z_W + 1)'(szm1);

  always_comb begin
    ctl_next.shift = (s_tuser == CMD_DRAIN) ? !can_take : can_take;
    ctl_next.emit  = ctl_next.shift && ((s_tuser == CMD_DRAIN) || (in_z != '0));
    ctl_next.last  = ctl_next.emit && (ox == sxm1) && (oy == sym1) && (oz == szm1);
    ctl_next.x_lo  = ox == '0;
    ctl_next.x_hi  = ox == sxm1;
    ctl_next.y_lo  = oy == '0;
    ctl_next.y_hi  = oy == sym1;
    ctl_next.z_lo  = oz == '0;
    ctl_next.z_hi  = oz == szm1;
    ctl_next.z_en  = z_en;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      in_x <= '0;
      in_y <= '0;
      in_z <= '0;
      ox   <= '0;
      oy   <= '0;
      oz   <= '0;
    end else if (accept) begin
      if (ctl_next.last) begin
        in_x <= '0;
        in_y <= '0;
        in_z <= '0;
        ox   <= '0;
        oy   <= '0;
        oz   <= '0;
      end else begin
        if (s_tuser == CMD_SAMPLE && can_take) begin
          if (in_x == sxm1) begin
            in_x <= '0;
            if (in_y == sym1) begin
              in_y <= '0;
              in_z <= in_z + (SIZE_Z_W + 1)'(1);
            end else begin
              in_y <= in_y + YCW'(1);
            end
          end else begin
            in_x <= in_x + XCW'(1);
          end
        end
        if (ctl_next.emit) begin
          if (ox == sxm1) begin
            ox <= '0;
            if (oy == sym1) begin
              oy <= '0;
              oz <= oz + SIZE_Z_W'(1);
            end else begin
              oy <= oy + YCW'(1);
            end
          end else begin
            ox <= ox + XCW'(1);
          end
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_ctl   <= '0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      s1_ctl   <= ctl_next;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
      s1_ctl   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= s_tdata[SAMPLE_BITS-1:0];
    end
  end

  // neighbourhood window: taps at delays 0, P-X, P-1, P, P+1, P+X, 2P
  assign chain_shift = s1_valid && s1_go && s1_ctl.shift;
  assign tap_zp      = s1_sample;

  vlm_delay #(.WIDTH(SAMPLE_BITS), .DEPTH(PR_DEPTH)) u_dly_plane_a (
    .clk(clk), .rst(rst), .clear(cfg_hit), .shift(chain_shift),
    .len(len_pr), .din(tap_zp), .dout(tap_yp)
  );

  vlm_delay #(.WIDTH(SAMPLE_BITS), .DEPTH(ROW_DEPTH)) u_dly_row_a (
    .clk(clk), .rst(rst), .clear(cfg_hit), .shift(chain_shift),
    .len(ROW_LEN_W'(sxm1)), .din(tap_yp), .dout(tap_xp)
  );

  always_ff @(posedge clk) begin
    if (chain_shift) begin
      tap_c  <= tap_xp;
      tap_xm <= tap_c;
    end
  end

  vlm_delay #(.WIDTH(SAMPLE_BITS), .DEPTH(ROW_DEPTH)) u_dly_row_b (
    .clk(clk), .rst(rst), .clear(cfg_hit), .shift(chain_shift),
    .len(ROW_LEN_W'(sxm1)), .din(tap_xm), .dout(tap_ym)
  );

  vlm_delay #(.WIDTH(SAMPLE_BITS), .DEPTH(PR_DEPTH)) u_dly_plane_b (
    .clk(clk), .rst(rst), .clear(cfg_hit), .shift(chain_shift),
    .len(len_pr), .din(tap_ym), .dout(tap_zm)
  );

  // second differences with mirrored borders
  always_comb begin
    c_e = ACC_W'(tap_c);
    if (s1_ctl.x_lo) begin
      xsum = ACC_W'(tap_xp) <<< 1;
    end else if (s1_ctl.x_hi) begin
      xsum = ACC_W'(tap_xm) <<< 1;
    end else begin
      xsum = ACC_W'(tap_xp) + ACC_W'(tap_xm);
    end
    if (s1_ctl.y_lo) begin
      ysum = ACC_W'(tap_yp) <<< 1;
    end else if (s1_ctl.y_hi) begin
      ysum = ACC_W'(tap_ym) <<< 1;
    end else begin
      ysum = ACC_W'(tap_yp) + ACC_W'(tap_ym);
    end
    if (!s1_ctl.z_en) begin
      zsum = '0;
    end else if (s1_ctl.z_lo) begin
      zsum = (ACC_W'(tap_zp) <<< 1) - (c_e <<< 1);
    end else if (s1_ctl.z_hi) begin
      zsum = (ACC_W'(tap_zm) <<< 1) - (c_e <<< 1);
    end else begin
      zsum = ACC_W'(tap_zp) + ACC_W'(tap_zm) - (c_e <<< 1);
    end
    acc = xsum + ysum + zsum - (c_e <<< 2);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_valid && s1_go && s1_ctl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_go && s1_ctl.emit) begin
      m_tdata <= M_DATA_W'(acc[LAP_W-1:0]);
      m_tlast <= s1_ctl.last;
    end
  end

endmodule
